[sv/agss_pkg.sv]
// Shared types and constants for the adjacency matrix graph store.
`default_nettype none
package agss_pkg;

	localparam int VTX_W  = 6;
	localparam int EDGE_W = 12;
	localparam int CNT_W  = 7;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_LIST   = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

	typedef struct packed {
		logic [1:0]       func;
		logic [VTX_W-1:0] vertex_a;
		logic [VTX_W-1:0] vertex_b;
	} req_word_t;

	typedef struct packed {
		logic              status;
		logic              has_neighbor;
		logic [VTX_W-1:0]  neighbor;
		logic [EDGE_W-1:0] edge_total;
		logic              last;
	} res_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_QLOAD,
		ST_SCAN
	} state_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_REQ,
		EMIT_DONE,
		EMIT_NBR
	} emit_t;

	typedef struct packed {
		logic  cfg_wr;
		logic  capture;
		logic  wr_a;
		logic  wr_b;
		logic  cnt_step;
		logic  scan_step;
		logic  scan_from_ram;
		emit_t emit;
	} dp_cmd_t;

	typedef struct packed {
		logic       bad;
		logic [1:0] req_func;
		logic [1:0] item_func;
		logic       present;
		logic       self_loop;
		logic       rem_zero;
		logic       rem_last;
	} dp_stat_t;

endpackage
`default_nettype wire

[sv/agss_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module agss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[sv/agss_ctrl.sv]
// Controller state machine for the graph store.
`default_nettype none
module agss_ctrl
	import agss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     cfg_valid,
	input  wire dp_stat_t stat,
	output logic          busy,
	output logic          cfg_ready,
	output dp_cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	logic   change;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.emit  = EMIT_NONE;
		busy      = (state_q != ST_IDLE);
		cfg_ready = (state_q == ST_IDLE) && !start;
		cmd.cfg_wr = cfg_valid && cfg_ready;
		change    = (stat.item_func == FUNC_ADD) ? !stat.present : stat.present;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (stat.bad || stat.req_func == FUNC_NONE) begin
						cmd.emit = EMIT_REQ;
					end else begin
						cmd.capture = 1'b1;
						state_d = (stat.req_func == FUNC_LIST) ? ST_QLOAD : ST_EDGE_A;
					end
				end
			end
			ST_EDGE_A: begin
				if (change) begin
					cmd.wr_a     = 1'b1;
					cmd.cnt_step = 1'b1;
					if (stat.self_loop) begin
						cmd.emit = EMIT_DONE;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_EDGE_B;
					end
				end else begin
					cmd.emit = EMIT_DONE;
					state_d  = ST_IDLE;
				end
			end
			ST_EDGE_B: begin
				cmd.wr_b = 1'b1;
				cmd.emit = EMIT_DONE;
				state_d  = ST_IDLE;
			end
			ST_QLOAD, ST_SCAN: begin
				cmd.scan_from_ram = (state_q == ST_QLOAD);
				if (stat.rem_zero) begin
					cmd.emit = EMIT_DONE;
					state_d  = ST_IDLE;
				end else begin
					cmd.emit      = EMIT_NBR;
					cmd.scan_step = 1'b1;
					state_d       = stat.rem_last ? ST_IDLE : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_edge_b_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EDGE_B) |-> ($past(state_q) == ST_EDGE_A))
		else $error("mirror row write without first row write");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ($past(state_q) == ST_QLOAD || $past(state_q) == ST_SCAN))
		else $error("row scan entered without row load");
`endif

endmodule
`default_nettype wire

[sv/agss_dp.sv]
// Datapath: row memory, row valid bits, edge counter, neighbor scan, result register.
`default_nettype none
module agss_dp
	import agss_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	input  wire req_word_t        request,
	input  wire logic [CNT_W-1:0] cfg_data,
	output dp_stat_t              stat,
	output res_word_t             result,
	output logic                  result_strobe
);

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int ROW_W = MAX_VERTICES;
	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_VERTICES);

	logic [CNT_W-1:0]  vcount_q;
	logic [CNT_W-1:0]  n_live;
	logic [ROW_W-1:0]  mask;
	logic              a_bad;
	logic              b_bad;
	logic              bad;
	req_word_t         item_q;
	logic [ROW_W-1:0]  vld_q;
	logic              vld_s1;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     wsel;
	logic [AW-1:0]     ia;
	logic [AW-1:0]     ib;
	logic              we;
	logic              set_bit;
	logic [ROW_W-1:0]  rdata;
	logic [ROW_W-1:0]  row_rd;
	logic [ROW_W-1:0]  wdata;
	logic [ROW_W-1:0]  scan_q;
	logic [ROW_W-1:0]  src;
	logic [ROW_W-1:0]  low;
	logic [ROW_W-1:0]  rem_next;
	logic [AW-1:0]     idx;
	logic [EDGE_W-1:0] cnt_q;
	logic [EDGE_W-1:0] cnt_d;
	res_word_t         out_q;
	logic              strobe_q;

	// live vertex count and validity
	assign n_live = (vcount_q > MAX_N) ? MAX_N : vcount_q;
	assign a_bad  = ({1'b0, request.vertex_a} >= n_live);
	assign b_bad  = ({1'b0, request.vertex_b} >= n_live);

	always_comb begin
		case (request.func)
			FUNC_LIST: bad = a_bad;
			FUNC_NONE: bad = 1'b0;
			default:   bad = a_bad || b_bad;
		endcase
		for (int v = 0; v < ROW_W; v++) begin
			mask[v] = (CNT_W'(v) < n_live);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cmd.cfg_wr) begin
			vcount_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= request;
		end
	end

	// row memory
	assign ia      = item_q.vertex_a[AW-1:0];
	assign ib      = item_q.vertex_b[AW-1:0];
	assign raddr   = cmd.capture ? request.vertex_a[AW-1:0] : ib;
	assign row_rd  = rdata & {ROW_W{vld_s1}};
	assign set_bit = (item_q.func == FUNC_ADD);
	assign we      = cmd.wr_a || cmd.wr_b;
	assign waddr   = cmd.wr_a ? ia : ib;
	assign wsel    = cmd.wr_a ? ib : ia;

	always_comb begin
		wdata       = row_rd;
		wdata[wsel] = set_bit;
	end

	agss_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_VERTICES)
	) u_rows (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_q[raddr];
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	// neighbor scan: isolate lowest set bit
	assign src      = cmd.scan_from_ram ? (row_rd & mask) : scan_q;
	assign low      = src & (~src + ROW_W'(1));
	assign rem_next = src & ~low;

	always_comb begin
		idx = '0;
		for (int v = 0; v < ROW_W; v++) begin
			if (low[v]) begin
				idx = idx | AW'(v);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			scan_q <= rem_next;
		end
	end

	// edge counter
	always_comb begin
		cnt_d = cnt_q;
		if (cmd.cnt_step) begin
			if (set_bit) begin
				cnt_d = cnt_q + EDGE_W'(1);
			end else if (cnt_q != '0) begin
				cnt_d = cnt_q - EDGE_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.emit != EMIT_NONE);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.emit)
			EMIT_REQ: begin
				out_q.status       <= bad ? STATUS_INVALID : STATUS_OK;
				out_q.has_neighbor <= 1'b0;
				out_q.neighbor     <= '0;
				out_q.edge_total   <= cnt_d;
				out_q.last         <= 1'b1;
			end
			EMIT_DONE: begin
				out_q.status       <= STATUS_OK;
				out_q.has_neighbor <= 1'b0;
				out_q.neighbor     <= '0;
				out_q.edge_total   <= cnt_d;
				out_q.last         <= 1'b1;
			end
			EMIT_NBR: begin
				out_q.status       <= STATUS_OK;
				out_q.has_neighbor <= 1'b1;
				out_q.neighbor     <= VTX_W'(idx);
				out_q.edge_total   <= cnt_d;
				out_q.last         <= (rem_next == '0);
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

	assign result        = out_q;
	assign result_strobe = strobe_q;

	assign stat.bad       = bad;
	assign stat.req_func  = request.func;
	assign stat.item_func = item_q.func;
	assign stat.present   = row_rd[ib];
	assign stat.self_loop = (item_q.vertex_a == item_q.vertex_b);
	assign stat.rem_zero  = (src == '0);
	assign stat.rem_last  = (rem_next == '0);

`ifndef SYNTHESIS
	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> $past(cmd.cnt_step))
		else $error("edge counter moved without an edge update");

	a_nbr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && out_q.has_neighbor) |-> ({1'b0, out_q.neighbor} < n_live))
		else $error("neighbor beyond live vertex count");

	a_vld_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		((|($past(vld_q) & ~vld_q)) == 1'b0))
		else $error("row valid bit dropped");
`endif

endmodule
`default_nettype wire

[sv/adjacency_matrix_graph_store_unit.sv]
// Top level of the adjacency matrix graph store.
`default_nettype none
// Undirected graph store: a symmetric bit matrix of up to MAX_VERTICES rows plus an edge
// counter. A request is taken when start is high and busy is low; each result word is on
// result for one cycle with result_strobe high and cannot be stalled, so the receiver must
// take it then. Out-of-range requests and unused function codes are answered from idle. An
// edge add or remove ends at row a when the edge already matches or is a self-loop; else it
// is one read of row a, one write of row a and one write of the mirrored row b, the writes
// through the one write port of the row memory. A neighbor listing gives one neighbor word
// per cycle, lowest vertex first (one done word when there are none). Each result appears
// the cycle after it is formed. Rows are tracked by reset-cleared valid bits, so the block
// is ready right after reset with no clearing pass. vertex_count is written through the
// cfg channel while busy and start are both low.
module adjacency_matrix_graph_store_unit
	import agss_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire req_word_t        request,
	output res_word_t             result,
	output logic                  result_strobe,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	agss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cfg_valid(cfg_valid),
		.stat     (stat),
		.busy     (busy),
		.cfg_ready(cfg_ready),
		.cmd      (cmd)
	);

	agss_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.request      (request),
		.cfg_data     (cfg_data),
		.stat         (stat),
		.result       (result),
		.result_strobe(result_strobe)
	);

endmodule
`default_nettype wire

[verif/agss_graph_checker.sv]
`timescale 1ns / 100ps
// Watches the graph store's request, result and vertex_count channels, predicts each result word and compares it.
module agss_graph_checker
	import agss_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire req_word_t        request,
	input  wire res_word_t        result,
	input  wire logic             result_strobe,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data,
	input  wire logic             end_check,
	output int                    fail_count,
	output int                    words_checked,
	output int                    pending_words
);

	logic [63:0]       adj_row [64];
	logic [EDGE_W-1:0] edge_count;
	logic [CNT_W-1:0]  vtx_limit;
	res_word_t         result_words_due [$];
	bit                end_done;

	initial begin
		fail_count = 0;
		words_checked = 0;
		pending_words = 0;
		end_done = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		fail_count++;
	endtask

	function automatic res_word_t make_word(input logic st, input logic hn, input int nb,
			input logic lst, input logic [EDGE_W-1:0] total);
		res_word_t w;
		w.status = st;
		w.has_neighbor = hn;
		w.neighbor = nb[VTX_W-1:0];
		w.edge_total = total;
		w.last = lst;
		return w;
	endfunction

	task automatic apply_graph_op(input req_word_t w);
		int live;
		int top_nbr;
		live = (vtx_limit > MAX_VERTICES) ? MAX_VERTICES : int'(vtx_limit);
		top_nbr = -1;
		if (w.func == FUNC_NONE) begin
			result_words_due.push_back(make_word(STATUS_OK, 1'b0, 0, 1'b1, edge_count));
		end else if (w.func == FUNC_LIST) begin
			if (w.vertex_a >= live) begin
				result_words_due.push_back(make_word(STATUS_INVALID, 1'b0, 0, 1'b1, edge_count));
			end else begin
				for (int v = 0; v < live; v++) begin
					if (adj_row[w.vertex_a][v]) top_nbr = v;
				end
				if (top_nbr < 0) begin
					result_words_due.push_back(make_word(STATUS_OK, 1'b0, 0, 1'b1, edge_count));
				end else begin
					for (int v = 0; v <= top_nbr; v++) begin
						if (adj_row[w.vertex_a][v])
							result_words_due.push_back(make_word(STATUS_OK, 1'b1, v,
								v == top_nbr, edge_count));
					end
				end
			end
		end else if (w.vertex_a >= live || w.vertex_b >= live) begin
			result_words_due.push_back(make_word(STATUS_INVALID, 1'b0, 0, 1'b1, edge_count));
		end else begin
			if (w.func == FUNC_ADD) begin
				if (!adj_row[w.vertex_a][w.vertex_b]) begin
					adj_row[w.vertex_a][w.vertex_b] = 1'b1;
					adj_row[w.vertex_b][w.vertex_a] = 1'b1;
					edge_count = edge_count + 1'b1;
				end
			end else if (adj_row[w.vertex_a][w.vertex_b]) begin
				adj_row[w.vertex_a][w.vertex_b] = 1'b0;
				adj_row[w.vertex_b][w.vertex_a] = 1'b0;
				if (edge_count != 0) edge_count = edge_count - 1'b1;
			end
			result_words_due.push_back(make_word(STATUS_OK, 1'b0, 0, 1'b1, edge_count));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_word_t due;
		if (!arst_n) begin
			for (int r = 0; r < 64; r++) adj_row[r] = '0;
			edge_count = '0;
			vtx_limit = VCOUNT_RESET;
			result_words_due.delete();
			pending_words <= 0;
		end else begin
			if (result_strobe) begin
				if (result_words_due.size() == 0) begin
					report_mismatch($sformatf("result word %h with nothing expected", result));
				end else begin
					due = result_words_due.pop_front();
					words_checked++;
					if (result.status !== due.status)
						report_mismatch($sformatf("status %b, expected %b",
							result.status, due.status));
					if (result.has_neighbor !== due.has_neighbor)
						report_mismatch($sformatf("has_neighbor %b, expected %b",
							result.has_neighbor, due.has_neighbor));
					if (result.neighbor !== due.neighbor)
						report_mismatch($sformatf("neighbor %0d, expected %0d",
							result.neighbor, due.neighbor));
					if (result.edge_total !== due.edge_total)
						report_mismatch($sformatf("edge_total %0d, expected %0d",
							result.edge_total, due.edge_total));
					if (result.last !== due.last)
						report_mismatch($sformatf("last %b, expected %b",
							result.last, due.last));
				end
			end
			if (cfg_valid && cfg_ready) vtx_limit = cfg_data;
			if (start && !busy) apply_graph_op(request);
			if (end_check && !end_done) begin
				end_done = 1;
				if (result_words_due.size() != 0)
					report_mismatch($sformatf("%0d result words never arrived",
						result_words_due.size()));
				result_words_due.delete();
			end
			pending_words <= result_words_due.size();
		end
	end

endmodule

[verif/tb_adjacency_matrix_graph_store_unit.sv]
`timescale 1ns / 100ps
// Testbench top: drives requests and vertex_count writes into the store, gives the verdict.
module tb_adjacency_matrix_graph_store_unit;
	import agss_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 24;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_word_t        request;
	res_word_t        result;
	logic             result_strobe;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;
	logic             end_check;
	int               fail_count;
	int               words_checked;
	int               pending_words;
	int               cycles;
	int               items_sent;
	int               cfg_writes;
	int               idle_pct;
	int               live;
	int               count_plan [6];
	int               idle_plan [3];

	adjacency_matrix_graph_store_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result       (result),
		.result_strobe(result_strobe),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	agss_graph_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result       (result),
		.result_strobe(result_strobe),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.end_check    (end_check),
		.fail_count   (fail_count),
		.words_checked(words_checked),
		.pending_words(pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("adjacency_matrix_graph_store_unit verification failed");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] f, input int a, input int b);
		req_word_t w;
		w.func = f;
		w.vertex_a = a[VTX_W-1:0];
		w.vertex_b = b[VTX_W-1:0];
		start <= 1'b1;
		request <= w;
		do @(posedge clk); while (busy);
		items_sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			request <= req_word_t'($urandom);
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	task automatic wait_idle;
		start <= 1'b0;
		do @(posedge clk); while (pending_words != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_vertex_count(input int v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v[CNT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		live = (v > 64) ? 64 : v;
	endtask

	function automatic int pick_vertex(input bit stray);
		if (stray && live < 64) return $urandom_range(63, live);
		if (live == 0) return $urandom_range(63, 0);
		return $urandom_range(live - 1, 0);
	endfunction

	task automatic random_item(input int hub);
		int r;
		int a;
		int b;
		r = $urandom_range(0, 99);
		a = ($urandom_range(0, 1) && hub < live) ? hub : pick_vertex($urandom_range(0, 99) < 8);
		b = pick_vertex($urandom_range(0, 99) < 5);
		if (r < 3) send_item(FUNC_NONE, a, b);
		else if (r < 55) send_item(FUNC_ADD, a, b);
		else if (r < 75) send_item(FUNC_REMOVE, a, b);
		else send_item(FUNC_LIST, a, $urandom_range(0, 63));
	endtask

	initial begin
		int hub;
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		end_check <= 1'b0;
		items_sent = 0;
		cfg_writes = 0;
		live = 64;
		idle_pct = 13;
		count_plan = '{64, 1, 127, 2, 8, 64};
		count_plan[3] = $urandom_range(64, 2);
		idle_plan = '{0, 61, 13};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(FUNC_LIST, 0, 0);
		send_item(FUNC_ADD, 0, 63);
		send_item(FUNC_ADD, 0, 63);
		send_item(FUNC_ADD, 5, 5);
		send_item(FUNC_LIST, 0, 63);
		send_item(FUNC_LIST, 63, 0);
		send_item(FUNC_LIST, 5, 5);
		send_item(FUNC_ADD, 0, 1);
		send_item(FUNC_ADD, 0, 2);
		send_item(FUNC_LIST, 0, 0);
		send_item(FUNC_REMOVE, 0, 2);
		send_item(FUNC_REMOVE, 0, 2);
		send_item(FUNC_REMOVE, 5, 5);
		send_item(FUNC_NONE, 63, 63);
		send_item(FUNC_ADD, 63, 62);
		send_item(FUNC_LIST, 63, 0);
		write_vertex_count(10);
		send_item(FUNC_ADD, 12, 3);
		send_item(FUNC_ADD, 3, 12);
		send_item(FUNC_LIST, 63, 0);
		send_item(FUNC_LIST, 0, 0);
		send_item(FUNC_REMOVE, 0, 63);
		write_vertex_count(0);
		send_item(FUNC_ADD, 0, 0);
		send_item(FUNC_LIST, 0, 0);
		send_item(FUNC_NONE, 0, 0);
		write_vertex_count(127);
		send_item(FUNC_LIST, 0, 0);

		for (int p = 0; p < 6; p++) begin
			write_vertex_count(count_plan[p]);
			idle_pct = idle_plan[p % 3];
			hub = $urandom_range(63, 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item(hub);
		end

		wait_idle();
		end_check <= 1'b1;
		@(posedge clk);
		end_check <= 1'b0;
		@(posedge clk);
		$display("Sent %0d requests across %0d vertex_count settings; %0d result words checked.",
			items_sent, cfg_writes, words_checked);
		$display("Covered repeated and self-loop edges, neighbor scans, stray vertices, op code 3.");
		if (fail_count == 0) begin
			$display("adjacency_matrix_graph_store_unit verification clean");
		end else begin
			$display("adjacency_matrix_graph_store_unit verification failed");
		end
		$finish;
	end

endmodule
